@@ src/asd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asd_pkg
// Shared widths, register indexes, reset values and state codes of the
// accelerometer step detector.
// ----------------------------------------------------------------------------
package asd_pkg;

  // Field widths
  localparam int SAMPLE_W    = 16;
  localparam int MAX_SAMPLES = 16;
  localparam int CNT_W       = 5;   // holds 0..MAX_SAMPLES
  localparam int SUM_W       = 21;  // MAX_SAMPLES * SAMPLE_W range, signed
  localparam int OFFSET_W    = 16;
  localparam int AVG_W       = 17;
  localparam int WIDE_W      = 22;  // quotient plus offset before saturation
  localparam int STEP_W      = 32;
  localparam int CFG_W       = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_DATA_W  = 56;  // average + step count, padded to bytes
  localparam int OUT_USER_W  = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN   = 2'd2;

  // Reset values (Q8.8)
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 16'h0A00;   // 10.0
  localparam logic [AVG_W-1:0]    UP_RST     = 17'h00800;  // 8.0
  localparam logic [AVG_W-1:0]    DOWN_RST   = 17'h1FB00;  // -5.0

  // Saturation limits of the average
  localparam logic [AVG_W-1:0] AVG_MAX = 17'h0FFFF;
  localparam logic [AVG_W-1:0] AVG_MIN = 17'h10000;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_POST = 3'b100
  } seq_state_t;

  // Step detector states
  typedef enum logic [2:0] {
    DET_IDLE  = 3'b001,
    DET_ABOVE = 3'b010,
    DET_BELOW = 3'b100
  } det_state_t;

endpackage

@@ src/asd_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asd_div
// Bit-serial restoring divider: unsigned batch sum magnitude by the sample
// count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asd_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [asd_pkg::SUM_W-1:0]   dividend,
  input  logic [asd_pkg::CNT_W-1:0]   divisor,
  output logic                        done,
  output logic [asd_pkg::SUM_W-1:0]   quotient
);

  logic                        busy;
  logic [asd_pkg::CNT_W-1:0]   steps_left;
  logic [asd_pkg::CNT_W-1:0]   dvs;
  logic [asd_pkg::CNT_W-1:0]   rem;
  logic [asd_pkg::SUM_W-1:0]   shreg;
  logic [asd_pkg::CNT_W:0]     trial;
  logic                        fits;

  // Trial subtract of the next remainder digit
  assign trial = {rem, shreg[asd_pkg::SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign quotient = shreg;

  // Control: count down the quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      steps_left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy       <= 1'b1;
        steps_left <= asd_pkg::CNT_W'(asd_pkg::SUM_W - 1);
      end else if (busy) begin
        steps_left <= steps_left - 1'b1;
        if (steps_left == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift dividend out, quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      rem   <= fits ? asd_pkg::CNT_W'(trial - {1'b0, dvs}) : asd_pkg::CNT_W'(trial);
      shreg <= {shreg[asd_pkg::SUM_W-2:0], fits};
    end
  end

endmodule

@@ src/accel_step_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_step_detector
// Threshold step counter on batches of accelerometer samples: averages up
// to 16 samples of a batch, adds an offset and runs a three-state detector.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   tuser=action, tdata[15:0]=sample, tlast=last
//  m_axis    out  tdata[16:0]=average, tdata[48:17]=step_count,
//                 tuser[0]=step_detected, tuser[1]=led_on
//  cfg       in   cfg_we, cfg_index, cfg_data (no read-back)
//
//  A sample or start request leaves the input ready for the next one. A
//  request marked last holds the input through acceptance, the bit-serial
//  divider, a step to normalize and saturate, and a step to classify and
//  load the output register.
//  The result waits in the output register; if it is still held, the
//  finished batch waits in the classify state. Reset is synchronous and
//  restores the default offset and thresholds.
// ----------------------------------------------------------------------------
module accel_step_detector (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [asd_pkg::SAMPLE_W-1:0]      s_axis_tdata,   // sample
  input  logic                              s_axis_tuser,   // action
  input  logic                              s_axis_tlast,   // last
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [asd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // average, step_count, pad
  output logic [asd_pkg::OUT_USER_W-1:0]    m_axis_tuser,   // step_detected, led_on
  input  logic                              cfg_we,
  input  logic [asd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [asd_pkg::CFG_W-1:0]         cfg_data
);

  asd_pkg::seq_state_t                 state;
  asd_pkg::det_state_t                 det;
  logic [asd_pkg::OFFSET_W-1:0]        reg_offset;
  logic [asd_pkg::AVG_W-1:0]           reg_up;
  logic [asd_pkg::AVG_W-1:0]           reg_down;
  logic [asd_pkg::SUM_W-1:0]           sum;
  logic [asd_pkg::CNT_W-1:0]           cnt;
  logic [asd_pkg::STEP_W-1:0]          steps;
  logic                                led;
  logic                                neg;
  logic [asd_pkg::AVG_W-1:0]           avg;

  logic                                in_acc;
  logic                                use_sample;
  logic [asd_pkg::SUM_W-1:0]           sum_next;
  logic [asd_pkg::CNT_W-1:0]           cnt_next;
  logic [asd_pkg::SUM_W-1:0]           mag;
  logic                                div_start;
  logic                                div_done;
  logic [asd_pkg::SUM_W-1:0]           quot;
  logic [asd_pkg::SUM_W-1:0]           q_signed;
  logic [asd_pkg::WIDE_W-1:0]          avg_wide;
  logic [asd_pkg::AVG_W-1:0]           avg_sat;
  logic                                out_free;
  asd_pkg::det_state_t                 det_next;
  logic                                led_next;
  logic                                stepped;
  logic [asd_pkg::STEP_W-1:0]          steps_next;

  assign s_axis_tready = (state == asd_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Accumulate the first samples of a batch
  assign use_sample = cnt < asd_pkg::CNT_W'(asd_pkg::MAX_SAMPLES);
  assign sum_next   = use_sample
                    ? sum + {{(asd_pkg::SUM_W - asd_pkg::SAMPLE_W){s_axis_tdata[asd_pkg::SAMPLE_W-1]}},
                             s_axis_tdata}
                    : sum;
  assign cnt_next   = use_sample ? cnt + 1'b1 : cnt;
  assign mag        = sum_next[asd_pkg::SUM_W-1] ? (~sum_next + 1'b1) : sum_next;
  assign div_start  = in_acc && !s_axis_tuser && s_axis_tlast;

  asd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (cnt_next),
    .done     (div_done),
    .quotient (quot)
  );

  // Restore sign, add offset, saturate to the average range
  assign q_signed = neg ? (~quot + 1'b1) : quot;
  assign avg_wide = {{(asd_pkg::WIDE_W - asd_pkg::SUM_W){q_signed[asd_pkg::SUM_W-1]}}, q_signed}
                  + {{(asd_pkg::WIDE_W - asd_pkg::OFFSET_W){reg_offset[asd_pkg::OFFSET_W-1]}},
                     reg_offset};
  always_comb begin
    avg_sat = avg_wide[asd_pkg::AVG_W-1:0];
    if (avg_wide[asd_pkg::WIDE_W-1:asd_pkg::AVG_W-1] != '0 &&
        avg_wide[asd_pkg::WIDE_W-1:asd_pkg::AVG_W-1] != '1) begin
      avg_sat = avg_wide[asd_pkg::WIDE_W-1] ? asd_pkg::AVG_MIN : asd_pkg::AVG_MAX;
    end
  end

  // Classify the batch average
  always_comb begin
    det_next = det;
    led_next = led;
    stepped  = 1'b0;
    unique case (det)
      asd_pkg::DET_ABOVE: begin
        if ($signed(avg) < $signed(reg_up)) begin
          det_next = asd_pkg::DET_IDLE;
          led_next = 1'b0;
        end
      end
      asd_pkg::DET_BELOW: begin
        if ($signed(avg) > $signed(reg_down)) begin
          det_next = asd_pkg::DET_IDLE;
          led_next = 1'b0;
        end
      end
      default: begin
        det_next = asd_pkg::DET_IDLE;
        if ($signed(avg) > $signed(reg_up)) begin
          det_next = asd_pkg::DET_ABOVE;
          stepped  = 1'b1;
        end else if ($signed(avg) < $signed(reg_down)) begin
          det_next = asd_pkg::DET_BELOW;
          stepped  = 1'b1;
        end
        if (stepped) begin
          led_next = 1'b1;
        end
      end
    endcase
  end
  assign steps_next = stepped ? steps + 1'b1 : steps;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_offset <= asd_pkg::OFFSET_RST;
      reg_up     <= asd_pkg::UP_RST;
      reg_down   <= asd_pkg::DOWN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        asd_pkg::REG_OFFSET: reg_offset <= cfg_data[asd_pkg::OFFSET_W-1:0];
        asd_pkg::REG_UP:     reg_up     <= cfg_data;
        asd_pkg::REG_DOWN:   reg_down   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, batch and detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= asd_pkg::ST_IDLE;
      det           <= asd_pkg::DET_IDLE;
      sum           <= '0;
      cnt           <= '0;
      steps         <= '0;
      led           <= 1'b0;
      neg           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Load a new result, or drop the old one once it is taken
      if (state == asd_pkg::ST_POST && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        asd_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser) begin
              // start request: clear count and detector
              steps <= '0;
              det   <= asd_pkg::DET_IDLE;
            end else if (s_axis_tlast) begin
              neg   <= sum_next[asd_pkg::SUM_W-1];
              sum   <= '0;
              cnt   <= '0;
              state <= asd_pkg::ST_DIV;
            end else begin
              sum <= sum_next;
              cnt <= cnt_next;
            end
          end
        end
        asd_pkg::ST_DIV: begin
          if (div_done) begin
            state <= asd_pkg::ST_POST;
          end
        end
        asd_pkg::ST_POST: begin
          // hold until the output register is free
          if (out_free) begin
            det           <= det_next;
            led           <= led_next;
            steps         <= steps_next;
            state         <= asd_pkg::ST_IDLE;
          end
        end
        default: state <= asd_pkg::ST_IDLE;
      endcase
    end
  end

  // Average register and output payload
  always_ff @(posedge clk) begin
    if (div_done) begin
      avg <= avg_sat;
    end
    if (state == asd_pkg::ST_POST && out_free) begin
      m_axis_tdata <= {{(asd_pkg::OUT_DATA_W - asd_pkg::STEP_W - asd_pkg::AVG_W){1'b0}},
                       steps_next, avg};
      m_axis_tuser <= {led_next, stepped};
    end
  end

endmodule
